FILE: hdl/atp_pkg.sv
// Shared types, constants and helpers for the octant-polynomial atan2 block.
`default_nettype none
package atp_pkg;

  // Coordinate and ratio widths
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned MAG_W      = 32;
  localparam int unsigned REM_W      = MAG_W + 1;
  localparam int unsigned RATIO_W    = 17;
  localparam int unsigned DIV_STAGES = RATIO_W;
  localparam int unsigned ANGLE_W    = 15;
  localparam int unsigned ANG_W      = 36;
  localparam int unsigned ANG_FRAC   = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Polynomial constants, Q16
  localparam logic [15:0] PI4_Q16 = 16'd51472;
  localparam logic [15:0] C1_Q16  = 16'd16037;
  localparam logic [15:0] C2_Q16  = 16'd4345;

  // Octant offsets, Q32
  localparam logic signed [ANG_W-1:0] HALF_PI_Q32 = 36'sd6746518852;
  localparam logic signed [ANG_W-1:0] PI_Q32      = 36'sd13493037705;

  // Output clamp limits
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -15'sd16384;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 15'sd16383;

  typedef enum logic [2:0] {
    OFS_ZERO     = 3'd0,
    OFS_POS_HALF = 3'd1,
    OFS_NEG_HALF = 3'd2,
    OFS_POS_PI   = 3'd3,
    OFS_NEG_PI   = 3'd4
  } offset_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } coord_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      at_origin;
  } result_t;

  // Per-item tags that ride along the back pipeline
  typedef struct packed {
    logic    flip;
    offset_e ofs;
    logic    origin;
  } meta_t;

  // One classified word held in the queue
  typedef struct packed {
    logic [MAG_W-1:0] num_mag;
    logic [MAG_W-1:0] den_mag;
    meta_t            meta;
  } work_t;

  // Map an octant offset code to its Q32 angle
  function automatic logic signed [ANG_W-1:0] ofs_value(input offset_e ofs);
    logic signed [ANG_W-1:0] val;
    case (ofs)
      OFS_POS_HALF: val = HALF_PI_Q32;
      OFS_NEG_HALF: val = -HALF_PI_Q32;
      OFS_POS_PI:   val = PI_Q32;
      OFS_NEG_PI:   val = -PI_Q32;
      default:      val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/atp_front.sv
// Front end: accepts a point, takes magnitudes and picks the octant.
`default_nettype none
module atp_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire atp_pkg::coord_t coord_i,
  output logic                 push_o,
  output atp_pkg::work_t       work_o,
  input  wire logic            ready_i
);

  logic                 sx, sy;
  logic [atp_pkg::MAG_W-1:0] ax, ay;
  logic                 swap;
  atp_pkg::work_t       work_d;
  atp_pkg::work_t       work_q;
  logic                 valid_d, valid_q;
  logic                 accept;

  // Classify the incoming point
  always_comb begin
    sx   = coord_i.coord_x[atp_pkg::COORD_W-1];
    sy   = coord_i.coord_y[atp_pkg::COORD_W-1];
    ax   = sx ? atp_pkg::MAG_W'(-coord_i.coord_x) : atp_pkg::MAG_W'(coord_i.coord_x);
    ay   = sy ? atp_pkg::MAG_W'(-coord_i.coord_y) : atp_pkg::MAG_W'(coord_i.coord_y);
    swap = !(ay < ax);
    work_d.num_mag     = swap ? ax : ay;
    work_d.den_mag     = swap ? ay : ax;
    work_d.meta.flip   = sx ^ sy ^ swap;
    work_d.meta.origin = (ax == '0) && (ay == '0);
    if (swap) begin
      work_d.meta.ofs = sy ? atp_pkg::OFS_NEG_HALF : atp_pkg::OFS_POS_HALF;
    end else if (sx) begin
      work_d.meta.ofs = sy ? atp_pkg::OFS_NEG_PI : atp_pkg::OFS_POS_PI;
    end else begin
      work_d.meta.ofs = atp_pkg::OFS_ZERO;
    end
  end

  assign busy   = valid_q && !ready_i;
  assign accept = start && !busy;
  assign push_o = valid_q;
  assign work_o = work_q;

  // Hold the word until the queue takes it
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      work_q <= work_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/atp_queue.sv
// Short queue between the front end and the back pipeline.
`default_nettype none
module atp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire atp_pkg::work_t work_i,
  output logic                ready_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output atp_pkg::work_t      head_o
);

  localparam int unsigned PTR_W = $clog2(atp_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(atp_pkg::QUEUE_DEPTH + 1);

  atp_pkg::work_t mem_q [atp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign ready_o = (count_q != CNT_W'(atp_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Track fill level
  always_comb begin
    count_d = count_q;
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(atp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(atp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= work_i;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/atp_back.sv
// Back pipeline: restoring ratio divider, polynomial, octant offset, rounding.
`default_nettype none
module atp_back #(
  parameter int unsigned FRACTION_BITS = 12
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire atp_pkg::work_t work_i,
  output logic                pop_o,
  output logic                done_o,
  output atp_pkg::result_t    result_o
);

  localparam int unsigned MAG_W  = atp_pkg::MAG_W;
  localparam int unsigned REM_W  = atp_pkg::REM_W;
  localparam int unsigned QUO_W  = atp_pkg::RATIO_W;
  localparam int unsigned NSTG   = atp_pkg::DIV_STAGES;
  localparam int unsigned ANG_W  = atp_pkg::ANG_W;
  localparam int unsigned SH     = atp_pkg::ANG_FRAC - FRACTION_BITS;
  localparam logic [ANG_W-1:0] HALF_LSB = ANG_W'(1) << (SH - 1);

  // The pipeline never stalls, so take every queued word
  assign pop_o = valid_i;

  // Divider stages: one quotient bit each, MSB first
  logic                 vld_q  [NSTG];
  logic [REM_W-1:0]     rem_q  [NSTG];
  logic [QUO_W-1:0]     quo_q  [NSTG];
  logic [MAG_W-1:0]     den_q  [NSTG];
  atp_pkg::meta_t       meta_q [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_div
    logic [REM_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [MAG_W-1:0] den_in;
    atp_pkg::meta_t   meta_in;
    logic             vld_in;
    logic [REM_W:0]   diff;
    logic             qbit;

    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, work_i.num_mag};
      assign quo_in  = '0;
      assign den_in  = work_i.den_mag;
      assign meta_in = work_i.meta;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = {rem_q[k-1][REM_W-2:0], 1'b0};
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign meta_in = meta_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Trial subtract of the divisor
    assign diff = {1'b0, rem_in} - {2'b00, den_in};
    assign qbit = !diff[REM_W];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= qbit ? diff[REM_W-1:0] : rem_in;
      quo_q[k]  <= {quo_in[QUO_W-2:0], qbit};
      den_q[k]  <= den_in;
      meta_q[k] <= meta_in;
    end
  end

  // Ratio magnitude a, Q1.16; at most one as num <= den, but for the origin
  logic [QUO_W-1:0] ratio;
  atp_pkg::meta_t   div_meta;
  assign ratio    = quo_q[NSTG-1];
  assign div_meta = meta_q[NSTG-1];

  // Stage P1: polynomial factors
  logic               p1_vld_q;
  atp_pkg::meta_t     p1_meta_q;
  logic [30:0]        poly_q, p_q;
  logic [32:0]        pi4a_q;
  logic [30:0]        poly_d;
  logic [QUO_W-1:0]   comp;
  logic [2*QUO_W-1:0] p_full;

  always_comb begin
    comp   = QUO_W'(17'd65536 - ratio);
    p_full = ratio * comp;
    poly_d = (31'(atp_pkg::C1_Q16) << 16) + 31'(31'(atp_pkg::C2_Q16) * 31'(ratio));
  end

  // Stage P2: product of the factors
  logic           p2_vld_q;
  atp_pkg::meta_t p2_meta_q;
  logic [61:0]    prod_q;
  logic [32:0]    p2_pi4a_q;

  // Stage P3: atan magnitude f, Q32
  logic           p3_vld_q;
  atp_pkg::meta_t p3_meta_q;
  logic [33:0]    f_q;

  // Stage P4: signed angle with octant offset, Q32
  logic                    p4_vld_q;
  logic                    p4_origin_q;
  logic signed [ANG_W-1:0] ang_q;
  logic signed [ANG_W-1:0] fs;
  logic signed [ANG_W-1:0] ang_d;

  always_comb begin
    fs    = $signed({2'b00, f_q});
    ang_d = atp_pkg::ofs_value(p3_meta_q.ofs) + (p3_meta_q.flip ? -fs : fs);
  end

  // Stage P5: sign and magnitude
  logic             p5_vld_q;
  logic             p5_origin_q;
  logic             p5_neg_q;
  logic [ANG_W-1:0] mag_q;

  // Output: round half away from zero, then clamp
  logic [ANG_W-1:0]                 rnd;
  logic signed [atp_pkg::ANGLE_W-1:0] angle_d;

  always_comb begin
    rnd = (mag_q + HALF_LSB) >> SH;
    if (p5_neg_q) begin
      angle_d = (rnd > ANG_W'(16384)) ? atp_pkg::ANGLE_MIN
                                       : atp_pkg::ANGLE_W'(-rnd);
    end else begin
      angle_d = (rnd > ANG_W'(16383)) ? atp_pkg::ANGLE_MAX
                                       : atp_pkg::ANGLE_W'(rnd);
    end
    if (p5_origin_q) begin
      angle_d = '0;
    end
  end

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
      p5_vld_q <= 1'b0;
      done_o   <= 1'b0;
    end else begin
      p1_vld_q <= vld_q[NSTG-1];
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      p4_vld_q <= p3_vld_q;
      p5_vld_q <= p4_vld_q;
      done_o   <= p5_vld_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    p1_meta_q <= div_meta;
    poly_q    <= poly_d;
    p_q       <= p_full[30:0];
    pi4a_q    <= 33'(atp_pkg::PI4_Q16) * 33'(ratio);

    p2_meta_q <= p1_meta_q;
    prod_q    <= 62'(p_q) * 62'(poly_q);
    p2_pi4a_q <= pi4a_q;

    p3_meta_q <= p2_meta_q;
    f_q       <= 34'(p2_pi4a_q) + 34'(prod_q[61:32]);

    p4_origin_q <= p3_meta_q.origin;
    ang_q       <= ang_d;

    p5_origin_q <= p4_origin_q;
    p5_neg_q    <= ang_q[ANG_W-1];
    mag_q       <= ang_q[ANG_W-1] ? ANG_W'(-ang_q) : ANG_W'(ang_q);

    result_o.angle     <= angle_d;
    result_o.at_origin <= p5_origin_q;
  end

endmodule
`default_nettype wire

FILE: hdl/atan2_octant_polynomial.sv
// Top level of the octant-polynomial atan2 block.
`default_nettype none
// Takes one point (coord_x, coord_y, signed Q20.12) per clock on start and
// returns its angle in radians (signed, FRACTION_BITS fraction bits, Q3.12 by
// default) with a one-cycle done_o strobe. Results come out in order, one per
// accepted word, and cannot be held off. Each point passes a front register,
// the queue, the 17-stage restoring divider that forms the ratio, one quotient
// bit per stage, and six polynomial, offset and rounding stages. A new point
// can be taken every cycle; busy stays low in normal use since the back
// pipeline never stalls. The origin gives angle 0 with at_origin set.
module atan2_octant_polynomial #(
  parameter int unsigned FRACTION_BITS = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire atp_pkg::coord_t  coord_i,
  output logic                  done_o,
  output atp_pkg::result_t      result_o
);

  localparam int unsigned LAT_CYCLES = 25;

  logic           f_push;
  atp_pkg::work_t f_work;
  logic           q_ready;
  logic           q_valid;
  atp_pkg::work_t q_head;
  logic           b_pop;

  atp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .coord_i (coord_i),
    .push_o  (f_push),
    .work_o  (f_work),
    .ready_i (q_ready)
  );

  atp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .work_i  (f_work),
    .ready_o (q_ready),
    .pop_i   (b_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  atp_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .work_i   (q_head),
    .pop_o    (b_pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // Every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT_CYCLES done_o)
    else $error("result missing after fixed latency");

  // The back pipeline drains every cycle, so the front never backs up
  a_no_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised although back pipeline never stalls");

  // Origin results carry a zero angle
  a_origin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.at_origin) |-> (result_o.angle == '0))
    else $error("origin result with nonzero angle");

endmodule
`default_nettype wire

FILE: dv/tb_atan2_octant_polynomial.sv
// Self-checking testbench for the octant-polynomial atan2 block.
module tb_atan2_octant_polynomial;

  localparam int unsigned FRAC_BITS    = 12;
  localparam int unsigned LATENCY      = 25;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_WORDS = 426;

  // Predictor constants: Q16 polynomial terms, Q32 octant offsets
  localparam logic [63:0] QUARTER_PI_Q16   = 64'd51472;
  localparam logic [63:0] LIN_COEF_Q16     = 64'd16037;
  localparam logic [63:0] SQR_COEF_Q16     = 64'd4345;
  localparam logic [63:0] RATIO_ONE        = 64'd65536;
  localparam longint      QUARTER_TURN_Q32 = 64'sd6746518852;
  localparam longint      HALF_TURN_Q32    = 64'sd13493037705;
  localparam longint      ANGLE_LO         = -64'sd16384;
  localparam longint      ANGLE_HI         = 64'sd16383;

  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  atp_pkg::coord_t  coord_i;
  logic             done_o;
  atp_pkg::result_t result_o;

  atp_pkg::result_t pending_angles[$];
  atp_pkg::result_t oldest_angle;
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;

  atan2_octant_polynomial #(
    .FRACTION_BITS(FRAC_BITS)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .coord_i (coord_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // Free-running clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Signed Q32 arctangent of num/den for a ratio magnitude in [0,1]
  function automatic longint signed_ratio_atan(input longint num, input longint den);
    logic [63:0] nm, dm, a, poly, p, f;
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    if (dm == 0) return 0;
    a = (nm << 16) / dm;
    if (a > RATIO_ONE) a = RATIO_ONE;
    poly = (LIN_COEF_Q16 << 16) + SQR_COEF_Q16 * a;
    p    = a * (RATIO_ONE - a);
    f    = QUARTER_PI_Q16 * a + ((p * poly) >> 32);
    return ((num < 0) != (den < 0)) ? -longint'(f) : longint'(f);
  endfunction

  // Expected angle word for one point
  function automatic atp_pkg::result_t predict_angle(input atp_pkg::coord_t pt);
    longint           x, y, ang, q;
    logic [63:0]      ax, ay, mag;
    int unsigned      sh;
    atp_pkg::result_t r;
    sh = 32 - FRAC_BITS;
    x  = {{32{pt.coord_x[31]}}, pt.coord_x};
    y  = {{32{pt.coord_y[31]}}, pt.coord_y};
    r  = '0;
    if (x == 0 && y == 0) begin
      r.at_origin = 1'b1;
      return r;
    end
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    // Pick the octant: ratio y/x near the x axis, x/y near the y axis
    if (ay < ax) begin
      ang = signed_ratio_atan(y, x);
      if (x < 0) ang += (y >= 0) ? HALF_TURN_Q32 : -HALF_TURN_Q32;
    end else begin
      ang = ((y >= 0) ? QUARTER_TURN_Q32 : -QUARTER_TURN_Q32) - signed_ratio_atan(x, y);
    end
    // Round half away from zero, then saturate
    mag = (ang < 0) ? -ang : ang;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    q   = (ang < 0) ? -longint'(mag) : longint'(mag);
    if (q < ANGLE_LO) q = ANGLE_LO;
    if (q > ANGLE_HI) q = ANGLE_HI;
    r.angle = q[atp_pkg::ANGLE_W-1:0];
    return r;
  endfunction

  // Present one word and hold it until accepted
  task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y);
    atp_pkg::coord_t pt;
    pt.coord_x = x;
    pt.coord_y = y;
    @(negedge clk_i);
    start   <= 1'b1;
    coord_i <= pt;
    do @(posedge clk_i); while (busy);
    pending_angles.push_back(predict_angle(pt));
  endtask

  // Drop start for a random gap, mostly short, sometimes long
  task automatic idle_gap();
    int unsigned roll, len;
    roll = $urandom_range(0, 99);
    if (roll < 55) len = 0;
    else if (roll < 90) len = $urandom_range(1, 3);
    else len = $urandom_range(8, 40);
    if (len == 0) return;
    @(negedge clk_i);
    start <= 1'b0;
    repeat (len - 1) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] extreme_value();
    case ($urandom_range(0, 5))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return 32'sd0;
      3: return 32'sd1;
      4: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_origin_and_axes();
    send_point(0, 0);           idle_gap();
    send_point(1, 0);           idle_gap();
    send_point(-1, 0);          idle_gap();
    send_point(0, 1);           idle_gap();
    send_point(0, -1);          idle_gap();
    send_point(COORD_MAX, 0);   idle_gap();
    send_point(COORD_MIN, 0);   idle_gap();
    send_point(0, COORD_MAX);   idle_gap();
    send_point(0, COORD_MIN);   idle_gap();
  endtask

  task automatic test_range_extremes();
    send_point(COORD_MIN, COORD_MIN); idle_gap();
    send_point(COORD_MAX, COORD_MAX); idle_gap();
    send_point(COORD_MIN, COORD_MAX); idle_gap();
    send_point(COORD_MAX, COORD_MIN); idle_gap();
    // Negative x just off the axis: angle near +pi and -pi
    send_point(COORD_MIN, 1);         idle_gap();
    send_point(COORD_MIN, -1);        idle_gap();
    send_point(1, COORD_MIN);         idle_gap();
    send_point(COORD_MAX, 1);         idle_gap();
  endtask

  task automatic test_octant_diagonals();
    send_point(1, 1);           idle_gap();
    send_point(-1, 1);          idle_gap();
    send_point(-1, -1);         idle_gap();
    send_point(1, -1);          idle_gap();
    send_point(4096, 4095);     idle_gap();
    send_point(4095, 4096);     idle_gap();
    send_point(-4096, -4095);   idle_gap();
  endtask

  task automatic test_random_points(input int unsigned count);
    logic signed [31:0] x, y, m, d, t;
    bit                 burst;
    for (int unsigned i = 0; i < count; i++) begin
      // Switch between back-to-back stretches and gapped stretches
      if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          x = $urandom;
          y = $urandom;
        end
        3, 4: begin
          x = int'($urandom_range(0, 8192)) - 4096;
          y = int'($urandom_range(0, 8192)) - 4096;
        end
        5, 6: begin
          // Near the diagonals, at many scales
          m = $urandom >> $urandom_range(1, 31);
          d = int'($urandom_range(0, 6)) - 3;
          x = $urandom_range(0, 1) ? m : -m;
          y = $urandom_range(0, 1) ? (m + d) : -(m + d);
        end
        7: begin
          if ($urandom_range(0, 1)) begin
            x = 0;
            y = $urandom;
          end else begin
            x = $urandom;
            y = 0;
          end
        end
        8: begin
          x = extreme_value();
          y = extreme_value();
        end
        default: begin
          x = $urandom;
          y = int'($urandom_range(0, 64)) - 32;
          if ($urandom_range(0, 1)) begin
            t = x;
            x = y;
            y = t;
          end
        end
      endcase
      send_point(x, y);
      if (!burst) idle_gap();
    end
  endtask

  // Compare each result word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_angles.size() == 0) begin
        $error("unexpected result word: angle %0d at_origin %0b",
               result_o.angle, result_o.at_origin);
        mismatch_count++;
      end else begin
        oldest_angle = pending_angles.pop_front();
        if (result_o.angle !== oldest_angle.angle) begin
          $error("angle mismatch: expected %0d, actual %0d",
                 oldest_angle.angle, result_o.angle);
          mismatch_count++;
        end
        if (result_o.at_origin !== oldest_angle.at_origin) begin
          $error("at_origin mismatch: expected %0b, actual %0b",
                 oldest_angle.at_origin, result_o.at_origin);
          mismatch_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    coord_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_origin_and_axes();
    test_range_extremes();
    test_octant_diagonals();
    test_random_points(RANDOM_WORDS);

    // Drain the pipeline, then watch for stray words
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/atp_pkg.sv
hdl/atp_front.sv
hdl/atp_queue.sv
hdl/atp_back.sv
hdl/atan2_octant_polynomial.sv
dv/tb_atan2_octant_polynomial.sv
